// ===== rtl/core/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// Deque package
// Sizes, field widths, command and status codes, controller states and the
// memory request bundle shared by the deque files.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Storage geometry. The ring wraps by address overflow, so DEPTH is a
  // power of two.
  localparam int DEPTH      = 256;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = ADDR_W + 1;

  // Field widths on the channels.
  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 8;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 8;
  localparam int COUNT_W  = 9;

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_GET_FRONT  = 3'd4,
    CMD_GET_BACK   = 3'd5,
    CMD_FIND_FRONT = 3'd6,
    CMD_FIND_BACK  = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_FIND
  } state_t;

  // One write port and one read port per cycle.
  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    word_t wr_data;
    logic  rd_en;
    addr_t rd_addr;
  } mem_req_t;

endpackage

// ===== rtl/core/dq_ifs.sv =====
// ----------------------------------------------------------------------------
// Deque channel interfaces
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface dq_in_if;
  logic                        valid;
  logic                        ready;
  logic [dq_pkg::CMD_W-1:0]    cmd;
  logic [dq_pkg::VALUE_W-1:0]  value;
  logic [dq_pkg::INDEX_W-1:0]  index;

  modport source (output valid, cmd, value, index, input ready);
  modport sink   (input valid, cmd, value, index, output ready);
endinterface

interface dq_out_if;
  logic                         valid;
  logic                         ready;
  logic [dq_pkg::STATUS_W-1:0]  status;
  logic [dq_pkg::VALUE_W-1:0]   data_out;
  logic [dq_pkg::POS_W-1:0]     position;
  logic [dq_pkg::COUNT_W-1:0]   count;

  modport source (output valid, status, data_out, position, count, input ready);
  modport sink   (input valid, status, data_out, position, count, output ready);
endinterface

// ===== rtl/core/dq_mem.sv =====
// ----------------------------------------------------------------------------
// Deque entry memory
// Ring storage with one write port and one read port; read data is
// registered and holds until the next read.
// ----------------------------------------------------------------------------
module dq_mem (
  input  logic             clk,
  input  dq_pkg::mem_req_t req,
  output dq_pkg::word_t    rd_data
);
  import dq_pkg::*;

  word_t mem [DEPTH];
  word_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Deque controller
// Holds the ring pointers and count, issues memory accesses for each command,
// walks the ring for searches and keeps the result word register.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  dq_in_if.sink            in_ch,
  dq_out_if.source         out_ch,
  output dq_pkg::mem_req_t mem_req,
  input  dq_pkg::word_t    mem_rd_data
);
  import dq_pkg::*;

  state_t state_r, state_nxt;
  addr_t  front_r, front_nxt;
  addr_t  back_r, back_nxt;
  cnt_t   cnt_r, cnt_nxt;

  // Search walk.
  word_t  key_r, key_nxt;
  logic   dir_back_r, dir_back_nxt;
  addr_t  scan_slot_r, scan_slot_nxt;
  addr_t  scan_idx_r, scan_idx_nxt;

  // Result word register.
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [VALUE_W-1:0]    out_data_r;
  logic [POS_W-1:0]      out_pos_r;
  logic [COUNT_W-1:0]    out_count_r;

  logic    out_free;
  logic    accept;
  logic    load_out;
  status_t res_status;
  word_t   res_data;
  addr_t   res_pos;
  cmd_t    cmd;
  addr_t   idx_slot;
  cnt_t    scan_next_idx;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE) && out_free;
  assign accept       = in_ch.valid && in_ch.ready;
  assign cmd          = cmd_t'(in_ch.cmd);
  assign idx_slot     = addr_t'(in_ch.index);
  assign scan_next_idx = cnt_t'(scan_idx_r) + cnt_t'(1);

  // Command decode, pointer updates and search stepping.
  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    cnt_nxt       = cnt_r;
    key_nxt       = key_r;
    dir_back_nxt  = dir_back_r;
    scan_slot_nxt = scan_slot_r;
    scan_idx_nxt  = scan_idx_r;
    mem_req       = '0;
    load_out      = 1'b0;
    res_status    = STAT_OK;
    res_data      = '0;
    res_pos       = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              load_out = 1'b1;
              if (cnt_r == cnt_t'(DEPTH)) begin
                res_status = STAT_FULL;
              end else begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_data = word_t'(in_ch.value);
                cnt_nxt         = cnt_r + cnt_t'(1);
                if (cmd == CMD_PUSH_FRONT) begin
                  front_nxt       = front_r - addr_t'(1);
                  mem_req.wr_addr = front_r - addr_t'(1);
                end else begin
                  mem_req.wr_addr = back_r;
                  back_nxt        = back_r + addr_t'(1);
                end
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (cnt_r == '0) begin
                load_out   = 1'b1;
                res_status = STAT_EMPTY;
              end else begin
                mem_req.rd_en = 1'b1;
                cnt_nxt       = cnt_r - cnt_t'(1);
                state_nxt     = ST_READ;
                if (cmd == CMD_POP_FRONT) begin
                  mem_req.rd_addr = front_r;
                  front_nxt       = front_r + addr_t'(1);
                end else begin
                  mem_req.rd_addr = back_r - addr_t'(1);
                  back_nxt        = back_r - addr_t'(1);
                end
              end
            end
            CMD_GET_FRONT, CMD_GET_BACK: begin
              if (32'(in_ch.index) >= 32'(cnt_r)) begin
                load_out   = 1'b1;
                res_status = STAT_EMPTY;
              end else begin
                mem_req.rd_en = 1'b1;
                state_nxt     = ST_READ;
                if (cmd == CMD_GET_FRONT) begin
                  mem_req.rd_addr = front_r + idx_slot;
                end else begin
                  mem_req.rd_addr = back_r - addr_t'(1) - idx_slot;
                end
              end
            end
            default: begin
              // Search: start at the front slot or the last slot.
              key_nxt      = word_t'(in_ch.value);
              dir_back_nxt = (cmd == CMD_FIND_BACK);
              scan_idx_nxt = '0;
              if (cmd == CMD_FIND_BACK) begin
                scan_slot_nxt = back_r - addr_t'(1);
              end else begin
                scan_slot_nxt = front_r;
              end
              if (cnt_r == '0) begin
                load_out   = 1'b1;
                res_status = STAT_EMPTY;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = scan_slot_nxt;
                state_nxt       = ST_FIND;
              end
            end
          endcase
        end
      end

      ST_READ: begin
        // Read data is back; hand it to the result register.
        if (out_free) begin
          load_out  = 1'b1;
          res_data  = mem_rd_data;
          state_nxt = ST_IDLE;
        end
      end

      ST_FIND: begin
        // Compare the entry just read and fetch the next one on a miss.
        if (out_free) begin
          if (mem_rd_data == key_r) begin
            load_out  = 1'b1;
            res_pos   = scan_idx_r;
            state_nxt = ST_IDLE;
          end else if (scan_next_idx < cnt_r) begin
            if (dir_back_r) begin
              scan_slot_nxt = scan_slot_r - addr_t'(1);
            end else begin
              scan_slot_nxt = scan_slot_r + addr_t'(1);
            end
            scan_idx_nxt    = scan_idx_r + addr_t'(1);
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = scan_slot_nxt;
          end else begin
            load_out   = 1'b1;
            res_status = STAT_EMPTY;
            state_nxt  = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      front_r <= '0;
      back_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      back_r  <= back_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Search context.
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    dir_back_r  <= dir_back_nxt;
    scan_slot_r <= scan_slot_nxt;
    scan_idx_r  <= scan_idx_nxt;
  end

  // Result word valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result word payload; the count is the one after this command.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= res_status;
      out_data_r   <= VALUE_W'(res_data);
      out_pos_r    <= POS_W'(res_pos);
      out_count_r  <= COUNT_W'(cnt_nxt);
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.data_out = out_data_r;
  assign out_ch.position = out_pos_r;
  assign out_ch.count    = out_count_r;

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue
// Push and rejected pops, gets and finds load the result on accept; pop and get
// read the memory first; find reads entries in turn from the chosen end.
// One word in flight; the next word is taken once the result has loaded and the output is free.
// Synchronous active-low reset empties the queue; the memory is not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue (
  input  logic     clk,
  input  logic     rst_n,
  dq_in_if.sink    in_ch,
  dq_out_if.source out_ch
);
  import dq_pkg::*;

  mem_req_t mem_req;
  word_t    mem_rd_data;

  // Command sequencing and result register.
  dq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data)
  );

  // Ring storage.
  dq_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

endmodule
